/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
package tcw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;

	localparam logic [ROW_W-1:0] MAX_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] MAX_COL = COL_W'(COLS - 1);

	localparam logic [15:0] BLANK_CELL = 16'h0220;
	localparam logic [7:0]  CH_NL      = 8'd10;
	localparam logic [7:0]  CH_CR      = 8'd13;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef logic [2:0] kind_t;
	localparam kind_t K_PUT   = 3'd0;
	localparam kind_t K_NL    = 3'd1;
	localparam kind_t K_CR    = 3'd2;
	localparam kind_t K_SET   = 3'd3;
	localparam kind_t K_CLEAR = 3'd4;
	localparam kind_t K_READ  = 3'd5;
	localparam kind_t K_NOP   = 3'd6;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

endpackage

/* design/tcw_front.sv */
`timescale 1ns / 1ps
module tcw_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic [7:0]                ch,
	input  logic [tcw_pkg::ROW_W-1:0] row,
	input  logic [tcw_pkg::COL_W-1:0] column,
	input  logic                      q_full,
	input  logic                      init_busy,
	output logic                      push,
	output tcw_pkg::cmd_t             cmd
);

	logic interpret_q;
	logic in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interpret_q <= 1'b1;
		end else if (cfg_wr_en) begin
			interpret_q <= cfg_wr_data;
		end
	end

	assign in_stall = q_full | init_busy;
	assign push     = in_valid & ~in_stall;
	assign in_range = (row <= tcw_pkg::MAX_ROW) && (column <= tcw_pkg::MAX_COL);

	always_comb begin
		cmd.kind = tcw_pkg::K_NOP;
		cmd.ch   = ch;
		cmd.row  = row;
		cmd.col  = column;
		cmd.addr = tcw_pkg::ADDR_W'(row) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
			+ tcw_pkg::ADDR_W'(column);
		unique case (op)
			tcw_pkg::OP_PUT: begin
				if (interpret_q && ch == tcw_pkg::CH_NL) begin
					cmd.kind = tcw_pkg::K_NL;
				end else if (interpret_q && ch == tcw_pkg::CH_CR) begin
					cmd.kind = tcw_pkg::K_CR;
				end else begin
					cmd.kind = tcw_pkg::K_PUT;
				end
			end
			tcw_pkg::OP_SET: begin
				cmd.kind = tcw_pkg::K_SET;
				cmd.row  = (row > tcw_pkg::MAX_ROW) ? tcw_pkg::MAX_ROW : row;
				cmd.col  = (column > tcw_pkg::MAX_COL) ? tcw_pkg::MAX_COL : column;
			end
			tcw_pkg::OP_CLEAR: begin
				cmd.kind = tcw_pkg::K_CLEAR;
			end
			default: begin
				cmd.kind = in_range ? tcw_pkg::K_READ : tcw_pkg::K_NOP;
			end
		endcase
	end

endmodule

/* design/tcw_cmd_fifo.sv */
`timescale 1ns / 1ps
module tcw_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_cmd,
	input  logic          pop,
	output tcw_pkg::cmd_t head_cmd,
	output logic          empty,
	output logic          full
);

	tcw_pkg::cmd_t                entry_q [tcw_pkg::QDEPTH];
	logic [tcw_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tcw_pkg::QPTR_W:0]   count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QDEPTH));
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/tcw_back.sv */
`timescale 1ns / 1ps
module tcw_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tcw_pkg::cmd_t             cmd,
	input  logic                      q_empty,
	output logic                      pop,
	output logic                      init_busy,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [tcw_pkg::ROW_W-1:0] cursor_row,
	output logic [tcw_pkg::COL_W-1:0] cursor_col,
	output logic [15:0]               cell_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_COPY = 2'd2;
	localparam logic [1:0] ST_FILL = 2'd3;

	localparam logic [tcw_pkg::ADDR_W-1:0] COPY_END = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
	localparam logic [tcw_pkg::ADDR_W-1:0] FILL_END = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);

	logic [7:0] char_mem [tcw_pkg::CELLS];
	logic [7:0] attr_mem [tcw_pkg::CELLS];

	logic [1:0]                  st_q, st_d;
	logic [tcw_pkg::ADDR_W-1:0]  cnt_q, cnt_d;
	logic                        emit_q, emit_d;
	logic [tcw_pkg::ROW_W-1:0]   cur_row_q, cur_row_d;
	logic [tcw_pkg::COL_W-1:0]   cur_col_q, cur_col_d;
	logic                        copy_v_s1, copy_v_d;
	logic [tcw_pkg::ADDR_W-1:0]  copy_addr_s1;
	logic [7:0]                  char_rd_q, attr_rd_q;
	logic                        out_valid_q;
	logic [tcw_pkg::ROW_W-1:0]   cursor_row_q;
	logic [tcw_pkg::COL_W-1:0]   cursor_col_q;
	logic [15:0]                 cell_data_q;

	logic                        out_free;
	logic                        load;
	logic [15:0]                 data_d;
	logic                        we;
	logic                        wae;
	logic [tcw_pkg::ADDR_W-1:0]  wa;
	logic [tcw_pkg::ADDR_W-1:0]  ra;
	logic [7:0]                  wc;
	logic [7:0]                  wat;
	logic [tcw_pkg::ADDR_W-1:0]  cur_addr;
	logic                        scroll;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign init_busy = (st_q == ST_FILL) & ~emit_q;
	assign cur_addr  = tcw_pkg::ADDR_W'(cur_row_q) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
		+ tcw_pkg::ADDR_W'(cur_col_q);

	always_comb begin
		st_d      = st_q;
		cnt_d     = cnt_q;
		emit_d    = emit_q;
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		copy_v_d  = 1'b0;
		pop       = 1'b0;
		load      = 1'b0;
		scroll    = 1'b0;
		data_d    = '0;
		we        = 1'b0;
		wae       = 1'b1;
		wa        = cnt_q;
		wc        = tcw_pkg::BLANK_CELL[7:0];
		wat       = tcw_pkg::BLANK_CELL[15:8];
		ra        = cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
		unique case (st_q)
			ST_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					unique case (cmd.kind)
						tcw_pkg::K_PUT: begin
							we  = 1'b1;
							wa  = cur_addr;
							wc  = cmd.ch;
							wae = 1'b0;
							if (cur_col_q == tcw_pkg::MAX_COL) begin
								cur_col_d = '0;
								if (cur_row_q == tcw_pkg::MAX_ROW) begin
									scroll = 1'b1;
								end else begin
									cur_row_d = cur_row_q + 1'b1;
								end
							end else begin
								cur_col_d = cur_col_q + 1'b1;
							end
						end
						tcw_pkg::K_NL: begin
							cur_col_d = '0;
							if (cur_row_q == tcw_pkg::MAX_ROW) begin
								scroll = 1'b1;
							end else begin
								cur_row_d = cur_row_q + 1'b1;
							end
						end
						tcw_pkg::K_CR: begin
							cur_col_d = '0;
						end
						tcw_pkg::K_SET: begin
							cur_row_d = cmd.row;
							cur_col_d = cmd.col;
						end
						tcw_pkg::K_CLEAR: begin
							st_d   = ST_FILL;
							cnt_d  = '0;
							emit_d = 1'b1;
						end
						tcw_pkg::K_READ: begin
							ra   = cmd.addr;
							st_d = ST_READ;
						end
						default: begin
						end
					endcase
					if (scroll) begin
						st_d   = ST_COPY;
						cnt_d  = '0;
						emit_d = 1'b1;
					end else if (cmd.kind != tcw_pkg::K_CLEAR && cmd.kind != tcw_pkg::K_READ) begin
						load = 1'b1;
					end
				end
			end
			ST_READ: begin
				load   = 1'b1;
				data_d = {attr_rd_q, char_rd_q};
				st_d   = ST_IDLE;
			end
			ST_COPY: begin
				if (cnt_q == COPY_END) begin
					st_d = ST_FILL;
				end else begin
					copy_v_d = 1'b1;
					cnt_d    = cnt_q + 1'b1;
				end
			end
			default: begin
				we = 1'b1;
				if (cnt_q == FILL_END) begin
					st_d   = ST_IDLE;
					load   = emit_q;
					emit_d = 1'b0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
		endcase
		if (copy_v_s1) begin
			we  = 1'b1;
			wae = 1'b1;
			wa  = copy_addr_s1;
			wc  = char_rd_q;
			wat = attr_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			char_mem[wa] <= wc;
		end
		char_rd_q <= char_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (we && wae) begin
			attr_mem[wa] <= wat;
		end
		attr_rd_q <= attr_mem[ra];
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= cnt_q;
		if (load) begin
			cursor_row_q <= cur_row_d;
			cursor_col_q <= cur_col_d;
			cell_data_q  <= data_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_FILL;
			cnt_q       <= '0;
			emit_q      <= 1'b0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			copy_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			cnt_q       <= cnt_d;
			emit_q      <= emit_d;
			cur_row_q   <= cur_row_d;
			cur_col_q   <= cur_col_d;
			copy_v_s1   <= copy_v_d;
			out_valid_q <= load | (out_valid_q & out_stall);
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign cell_data  = cell_data_q;

endmodule

/* design/text_console_writer_core.sv */
`timescale 1ns / 1ps
// Text console engine holding an 80 by 25 screen of attribute and character words.
// Commands arrive on the input channel (in_valid, in_stall, op, ch, row, column);
// every command returns one beat on the output channel (out_valid, out_stall,
// cursor_row, cursor_col, cell_data) carrying the cursor after the command.
// A two-entry command queue sits between the classifier and the executor.
// A put, newline, carriage return or set cursor with no scroll is done in ST_IDLE,
// so such beats stream at one per cycle while out_stall is low.
// A cell read passes through ST_READ because the screen memory read is registered.
// A clear screen is one write per cell; a scroll copies 1920 cells through the
// single read port and refills the bottom row.
// After reset the screen memory is filled with blanks, and in_stall is high for
// the whole fill; configuration writes are taken at any time.
// While out_stall is high the result register holds, and once the queue is full
// in_stall rises; nothing is lost.
module text_console_writer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic [7:0]                ch,
	input  logic [tcw_pkg::ROW_W-1:0] row,
	input  logic [tcw_pkg::COL_W-1:0] column,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [tcw_pkg::ROW_W-1:0] cursor_row,
	output logic [tcw_pkg::COL_W-1:0] cursor_col,
	output logic [15:0]               cell_data
);

	tcw_pkg::cmd_t push_cmd;
	tcw_pkg::cmd_t head_cmd;
	logic          push;
	logic          pop;
	logic          q_empty;
	logic          q_full;
	logic          init_busy;

	tcw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.ch          (ch),
		.row         (row),
		.column      (column),
		.q_full      (q_full),
		.init_busy   (init_busy),
		.push        (push),
		.cmd         (push_cmd)
	);

	tcw_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (head_cmd),
		.q_empty    (q_empty),
		.pop        (pop),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.cell_data  (cell_data)
	);

endmodule

/* design/tcw_checker.sv */
`timescale 1ns / 1ps
module tcw_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [tcw_pkg::ROW_W-1:0] cursor_row,
	input logic [tcw_pkg::COL_W-1:0] cursor_col,
	input logic [15:0]               cell_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result beat dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cursor_row) && $stable(cursor_col)
			&& $stable(cell_data))
		else $error("Stalled result beat changed.");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_row <= tcw_pkg::MAX_ROW && cursor_col <= tcw_pkg::MAX_COL)
		else $error("Cursor outside the screen.");

	a_reset_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall && !out_valid)
		else $error("Block active before the screen fill after reset.");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

/* dv/text_console_writer_checker.sv */
`timescale 1ns / 1ps
module text_console_writer_checker
	import tcw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       op,
	input  logic [7:0]       ch,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] column,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [ROW_W-1:0] cursor_row,
	input  logic [COL_W-1:0] cursor_col,
	input  logic [15:0]      cell_data,
	output int               pending,
	output int               failures
);

	typedef struct {
		logic [ROW_W-1:0] cur_row;
		logic [COL_W-1:0] cur_col;
		logic [15:0]      cell_word;
	} console_reply_t;

	logic [15:0]      screen [CELLS];
	logic [ROW_W-1:0] model_row;
	logic [COL_W-1:0] model_col;
	logic             controls_on;
	console_reply_t   awaited_replies [$];

	task automatic report_mismatch(string what, int got, int want);
		if (failures < 200)
			$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
		failures++;
	endtask

	function void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen[i] = BLANK_CELL;
	endfunction

	function void cursor_down();
		if (model_row >= MAX_ROW) begin
			model_row = MAX_ROW;
			for (int i = 0; i < CELLS - COLS; i++)
				screen[i] = screen[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen[i] = BLANK_CELL;
		end else begin
			model_row++;
		end
	endfunction

	function void write_char(logic [7:0] c);
		int addr;
		addr = int'(model_row) * COLS + int'(model_col);
		screen[addr][7:0] = c;
		if (model_col >= MAX_COL) begin
			model_col = '0;
			cursor_down();
		end else begin
			model_col++;
		end
	endfunction

	function console_reply_t execute_console_command(logic [1:0] o, logic [7:0] c,
			logic [ROW_W-1:0] r, logic [COL_W-1:0] col);
		console_reply_t reply;
		reply.cell_word = '0;
		case (o)
			OP_PUT: begin
				if (controls_on && c == CH_NL) begin
					model_col = '0;
					cursor_down();
				end else if (controls_on && c == CH_CR) begin
					model_col = '0;
				end else begin
					write_char(c);
				end
			end
			OP_SET: begin
				model_row = (r > MAX_ROW) ? MAX_ROW : r;
				model_col = (col > MAX_COL) ? MAX_COL : col;
			end
			OP_CLEAR: begin
				blank_screen();
			end
			default: begin
				if (r <= MAX_ROW && col <= MAX_COL)
					reply.cell_word = screen[int'(r) * COLS + int'(col)];
			end
		endcase
		reply.cur_row = model_row;
		reply.cur_col = model_col;
		return reply;
	endfunction

	always @(posedge clk) begin : watch
		console_reply_t want;
		if (!arst_n) begin
			blank_screen();
			model_row = '0;
			model_col = '0;
			controls_on = 1'b1;
			awaited_replies.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				controls_on = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (awaited_replies.size() == 0) begin
					report_mismatch("unexpected result beat", 0, 0);
				end else begin
					want = awaited_replies.pop_front();
					if (cursor_row !== want.cur_row)
						report_mismatch("cursor_row", cursor_row, want.cur_row);
					if (cursor_col !== want.cur_col)
						report_mismatch("cursor_col", cursor_col, want.cur_col);
					if (cell_data !== want.cell_word)
						report_mismatch("cell_data", cell_data, want.cell_word);
				end
			end
			if (in_valid && !in_stall)
				awaited_replies.push_back(execute_console_command(op, ch, row, column));
			pending <= awaited_replies.size();
		end
	end

endmodule

/* dv/text_console_writer_core_tb.sv */
`timescale 1ns / 1ps
module text_console_writer_core_tb;
	import tcw_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic             cfg_wr_data;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       op;
	logic [7:0]       ch;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] column;
	logic             out_valid;
	logic             out_stall;
	logic [ROW_W-1:0] cursor_row;
	logic [COL_W-1:0] cursor_col;
	logic [15:0]      cell_data;
	int               pending;
	int               failures;

	bit               calm;
	bit               hold_go;
	bit               hold_done;
	int               commands_sent;
	int               cycle_count;
	logic [ROW_W-1:0] line_row;
	logic [COL_W-1:0] line_col;

	text_console_writer_core dut (.*);

	text_console_writer_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The one long hold-off lets the command queue fill so that in_stall is exercised.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			out_stall <= 1'b1;
			hold_done = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 33);
		end
	end

	task automatic issue(logic [1:0] o, logic [7:0] c, logic [ROW_W-1:0] r,
			logic [COL_W-1:0] col);
		if (!calm) begin
			while ($urandom_range(0, 99) < 33) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		op       <= o;
		ch       <= c;
		row      <= r;
		column   <= col;
		do @(posedge clk); while (in_stall);
		commands_sent++;
	endtask

	task automatic set_controls(logic v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic noise_command();
		logic [1:0] o;
		o = 2'($urandom_range(0, 3));
		if (o == OP_CLEAR && $urandom_range(0, 7) != 0)
			o = OP_READ;
		issue(o, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
			7'($urandom_range(0, 127)));
	endtask

	// A line of text: place the cursor, type into it, then read back near it.
	task automatic type_line();
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		logic [7:0]       b;
		int               n;
		int               k;
		r = 5'($urandom_range(0, 31));
		c = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(80, 127)) : 7'($urandom_range(0, 79));
		issue(OP_SET, 8'($urandom_range(0, 255)), r, c);
		line_row = (r > MAX_ROW) ? MAX_ROW : r;
		line_col = (c > MAX_COL) ? MAX_COL : c;
		n = $urandom_range(1, 40);
		repeat (n) begin
			k = $urandom_range(0, 99);
			b = (k < 4) ? CH_NL : (k < 8) ? CH_CR : 8'($urandom_range(0, 255));
			issue(OP_PUT, b, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
		end
		repeat ($urandom_range(1, 3))
			issue(OP_READ, 8'($urandom_range(0, 255)), line_row - 5'($urandom_range(0, 1)),
				line_col + 7'($urandom_range(0, n)));
	endtask

	task automatic random_phase(int count);
		int target;
		int k;
		target = commands_sent + count;
		while (commands_sent < target) begin
			k = $urandom_range(0, 99);
			if (k < 70)
				type_line();
			else if (k < 72)
				issue(OP_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
					7'($urandom_range(0, 127)));
			else
				repeat ($urandom_range(1, 6)) noise_command();
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid    = 1'b0;
		op          = OP_PUT;
		ch          = '0;
		row         = '0;
		column      = '0;
		out_stall   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		set_controls(1'b1);
		issue(OP_SET, 8'h00, 5'd0, 7'd0);
		issue(OP_PUT, 8'h00, 5'd0, 7'd0);
		issue(OP_PUT, 8'hFF, 5'd0, 7'd0);
		issue(OP_READ, 8'h00, 5'd0, 7'd0);
		issue(OP_READ, 8'h00, 5'd0, 7'd1);
		issue(OP_SET, 8'h00, 5'd31, 7'd127);
		issue(OP_PUT, 8'h41, 5'd0, 7'd0);
		issue(OP_READ, 8'h00, 5'd23, 7'd79);
		issue(OP_READ, 8'h00, 5'd24, 7'd127);
		issue(OP_READ, 8'h00, 5'd31, 7'd0);
		issue(OP_SET, 8'h00, 5'd24, 7'd5);
		issue(OP_PUT, CH_NL, 5'd0, 7'd0);
		issue(OP_SET, 8'h00, 5'd3, 7'd7);
		issue(OP_PUT, CH_CR, 5'd0, 7'd0);
		issue(OP_PUT, CH_NL, 5'd0, 7'd0);
		issue(OP_CLEAR, 8'h00, 5'd0, 7'd0);
		issue(OP_READ, 8'h00, 5'd22, 7'd79);
		issue(OP_SET, 8'h00, 5'd0, 7'd79);
		issue(OP_PUT, 8'h7E, 5'd0, 7'd0);

		hold_go = 1'b1;
		random_phase(700);

		set_controls(1'b0);
		issue(OP_SET, 8'h00, 5'd2, 7'd0);
		issue(OP_PUT, CH_NL, 5'd0, 7'd0);
		issue(OP_PUT, CH_CR, 5'd0, 7'd0);
		issue(OP_READ, 8'h00, 5'd2, 7'd0);
		issue(OP_READ, 8'h00, 5'd2, 7'd1);
		calm = 1'b1;
		random_phase(450);
		calm = 1'b0;

		set_controls(1'b1);
		random_phase(800);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* text_console_writer_core.f */
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_cmd_fifo.sv
design/tcw_back.sv
design/text_console_writer_core.sv
design/tcw_checker.sv
dv/text_console_writer_checker.sv
dv/text_console_writer_core_tb.sv
